// ----- hdl/vpm_pkg.sv -----
package vpm_pkg;

  // Size limits
  localparam int SURFACE_MAX = 4096;
  localparam int CANVAS_MAX  = 8192;
  localparam int SCALE_MAX   = 16;

  // Configuration register widths and port
  localparam int CFG_SW_W   = 13;
  localparam int CFG_CW_W   = 14;
  localparam int MODE_W     = 2;
  localparam int SCALE_W    = 5;
  localparam int SCROLL_W   = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 3;

  // Register indices
  localparam logic [CFG_ADDR_W-1:0] REG_SURFACE_W = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SURFACE_H = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CANVAS_W  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CANVAS_H  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_VIEW_MODE = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_SCALE     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_SCROLL_X  = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SCROLL_Y  = 3'd7;

  // View modes
  localparam logic [MODE_W-1:0] VM_STRETCH = 2'd0;
  localparam logic [MODE_W-1:0] VM_ASPECT  = 2'd1;
  localparam logic [MODE_W-1:0] VM_INTEGER = 2'd2;
  localparam logic [MODE_W-1:0] VM_ONE     = 2'd3;

  // Derived datapath widths
  localparam int SZ_W  = $clog2(SURFACE_MAX + 1);
  localparam int CV_W  = $clog2(CANVAS_MAX + 1);
  localparam int SC_W  = $clog2(SCALE_MAX + 1);
  localparam int SN_W  = $clog2(SURFACE_MAX * SCALE_MAX + 1);
  localparam int DW_W  = (SN_W > CV_W) ? SN_W : CV_W;
  localparam int DX_W  = DW_W + 1;
  localparam int SR_W  = $clog2(SURFACE_MAX);
  localparam int PT_W  = 16;
  localparam int CL_W  = 12;
  localparam int DF_W  = ((PT_W > DX_W) ? PT_W : DX_W) + 1;
  localparam int PR_W  = DF_W + SZ_W;
  localparam int DVD_W = PR_W + (PR_W % 2);
  localparam int BPS   = 2;
  localparam int DIV_STAGES = DVD_W / BPS;

  // Aspect-fit divider widths
  localparam int PA_W = CV_W + SZ_W;
  localparam int AN_W = PA_W + 1;
  localparam int AD_W = SZ_W + 1;

  typedef struct packed {
    logic [CFG_SW_W-1:0] surface_width;
    logic [CFG_SW_W-1:0] surface_height;
    logic [CFG_CW_W-1:0] canvas_width;
    logic [CFG_CW_W-1:0] canvas_height;
    logic [MODE_W-1:0]   view_mode;
    logic [SCALE_W-1:0]  scale_factor;
    logic [SCROLL_W-1:0] scroll_x;
    logic [SCROLL_W-1:0] scroll_y;
  } cfg_t;

  typedef struct packed {
    logic signed [DX_W-1:0] off;
    logic [DW_W-1:0]        size;
    logic [SR_W-1:0]        src;
    logic [SZ_W-1:0]        surf;
  } ax_lay_t;

  typedef struct packed {
    logic    valid;
    logic    scaled;
    ax_lay_t x;
    ax_lay_t y;
  } lay_t;

  typedef struct packed {
    logic signed [PT_W-1:0] pointer_x;
    logic signed [PT_W-1:0] pointer_y;
  } pt_t;

  typedef struct packed {
    logic signed [PT_W-1:0] guest_x;
    logic signed [PT_W-1:0] guest_y;
    logic                   inside_res;
    logic                   layout_valid;
    logic [CL_W-1:0]        clamped_x;
    logic [CL_W-1:0]        clamped_y;
  } res_t;

endpackage

// ----- hdl/vpm_if.sv -----
interface vpm_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [vpm_pkg::PT_W-1:0] pointer_x;
  logic signed [vpm_pkg::PT_W-1:0] pointer_y;

  modport source (output valid, output pointer_x, output pointer_y, input ready);
  modport sink   (input valid, input pointer_x, input pointer_y, output ready);
endinterface

interface vpm_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [vpm_pkg::PT_W-1:0] guest_x;
  logic signed [vpm_pkg::PT_W-1:0] guest_y;
  logic                            inside_res;
  logic                            layout_valid;
  logic [vpm_pkg::CL_W-1:0]        clamped_x;
  logic [vpm_pkg::CL_W-1:0]        clamped_y;

  modport source (output valid, output guest_x, output guest_y, output inside_res,
                  output layout_valid, output clamped_x, output clamped_y, input ready);
  modport sink   (input valid, input guest_x, input guest_y, input inside_res,
                  input layout_valid, input clamped_x, input clamped_y, output ready);
endinterface

// ----- hdl/vpm_layout.sv -----
module vpm_layout (
  input  logic          clk,
  input  logic          rst_n,
  input  vpm_pkg::cfg_t cfg,
  input  logic          cfg_we,
  output vpm_pkg::lay_t lay,
  output logic          lay_rdy
);
  import vpm_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_PREP = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam int CNT_W = $clog2(AN_W);

  logic [2:0]       state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [PA_W-1:0]  pa_r, pb_r;
  logic [SN_W-1:0]  snx_r, sny_r;
  logic             wlim_r;
  logic [AN_W-1:0]  num_r, num_nxt;
  logic [AD_W-1:0]  den_r;
  logic [AD_W-1:0]  rem_r, rem_nxt;
  lay_t             lay_r;

  logic [SZ_W-1:0]  sw, sh;
  logic [CV_W-1:0]  cw, ch;
  logic [SC_W-1:0]  n;
  logic [AD_W:0]    t;
  logic [DW_W-1:0]  fit;

  // Saturated sizes and scale
  always_comb begin
    sw = (cfg.surface_width > CFG_SW_W'(SURFACE_MAX)) ? SZ_W'(SURFACE_MAX)
                                                       : SZ_W'(cfg.surface_width);
    sh = (cfg.surface_height > CFG_SW_W'(SURFACE_MAX)) ? SZ_W'(SURFACE_MAX)
                                                        : SZ_W'(cfg.surface_height);
    cw = (cfg.canvas_width > CFG_CW_W'(CANVAS_MAX)) ? CV_W'(CANVAS_MAX)
                                                     : CV_W'(cfg.canvas_width);
    ch = (cfg.canvas_height > CFG_CW_W'(CANVAS_MAX)) ? CV_W'(CANVAS_MAX)
                                                      : CV_W'(cfg.canvas_height);
    if (cfg.scale_factor == '0)
      n = SC_W'(1);
    else if (cfg.scale_factor > SCALE_W'(SCALE_MAX))
      n = SC_W'(SCALE_MAX);
    else
      n = SC_W'(cfg.scale_factor);
  end

  // One radix-2 step of the aspect-fit divider
  always_comb begin
    t       = {rem_r, num_r[AN_W-1]};
    num_nxt = {num_r[AN_W-2:0], 1'b0};
    if (t >= {1'b0, den_r}) begin
      t          = t - {1'b0, den_r};
      num_nxt[0] = 1'b1;
    end
    rem_nxt = t[AD_W-1:0];
  end

  // Fitted size of the non-limiting side, at least 1
  assign fit = (num_r == '0) ? DW_W'(1) : DW_W'(num_r);

  function automatic ax_lay_t axis_fin(input logic [MODE_W-1:0]   mode,
                                       input logic [SZ_W-1:0]     s,
                                       input logic [CV_W-1:0]     c,
                                       input logic [SCROLL_W-1:0] scr,
                                       input logic [SN_W-1:0]     sn,
                                       input logic [DW_W-1:0]     fw);
    ax_lay_t         a;
    logic [DW_W-1:0] cz, sz, nz, ov, lim;
    a      = '0;
    a.surf = s;
    cz     = DW_W'(c);
    sz     = DW_W'(s);
    nz     = DW_W'(sn);
    ov     = '0;
    lim    = '0;
    case (mode)
      VM_STRETCH: a.size = cz;
      VM_ASPECT: begin
        a.size = fw;
        a.off  = DX_W'((cz - fw) >> 1);
      end
      VM_INTEGER: begin
        a.size = nz;
        if (nz <= cz) begin
          a.off = DX_W'((cz - nz) >> 1);
        end else begin
          ov    = nz - cz;
          lim   = (DW_W'(scr) < ov) ? DW_W'(scr) : ov;
          a.off = -$signed({1'b0, lim});
        end
      end
      default: begin
        if (sz > cz) begin
          ov     = sz - cz;
          lim    = (DW_W'(scr) < ov) ? DW_W'(scr) : ov;
          a.src  = SR_W'(lim);
          a.size = cz;
        end else begin
          a.off  = DX_W'((cz - sz) >> 1);
          a.size = sz;
        end
      end
    endcase
    return a;
  endfunction

  // Sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_MUL;
      cnt_r   <= '0;
    end else if (cfg_we) begin
      state_r <= ST_MUL;
    end else begin
      unique case (state_r)
        ST_IDLE: state_r <= ST_IDLE;
        ST_MUL:  state_r <= ST_PREP;
        ST_PREP: begin
          state_r <= ST_DIV;
          cnt_r   <= CNT_W'(AN_W - 1);
        end
        ST_DIV: begin
          if (cnt_r == '0) state_r <= ST_FIN;
          else cnt_r <= cnt_r - 1'b1;
        end
        ST_FIN:  state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Layout datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_MUL: begin
        pa_r  <= cw * sh;
        pb_r  <= ch * sw;
        snx_r <= sw * n;
        sny_r <= sh * n;
      end
      ST_PREP: begin
        wlim_r <= (pa_r <= pb_r);
        num_r  <= (pa_r <= pb_r) ? ({pa_r, 1'b0} + AN_W'(sw)) : ({pb_r, 1'b0} + AN_W'(sh));
        den_r  <= (pa_r <= pb_r) ? {sw, 1'b0} : {sh, 1'b0};
        rem_r  <= '0;
      end
      ST_DIV: begin
        num_r <= num_nxt;
        rem_r <= rem_nxt;
      end
      ST_FIN: begin
        lay_r.valid  <= (sw != '0) && (sh != '0) && (cw != '0) && (ch != '0);
        lay_r.scaled <= (cfg.view_mode != VM_ONE);
        lay_r.x <= axis_fin(cfg.view_mode, sw, cw, cfg.scroll_x, snx_r,
                            wlim_r ? DW_W'(cw) : fit);
        lay_r.y <= axis_fin(cfg.view_mode, sh, ch, cfg.scroll_y, sny_r,
                            wlim_r ? fit : DW_W'(ch));
      end
      default: ;
    endcase
  end

  assign lay     = lay_r;
  assign lay_rdy = (state_r == ST_IDLE) && !cfg_we;

endmodule

// ----- hdl/vpm_map.sv -----
module vpm_map (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  vpm_pkg::pt_t  in_beat,
  input  logic          lay_rdy,
  input  vpm_pkg::lay_t lay,
  output logic          out_valid,
  input  logic          out_ready,
  output vpm_pkg::res_t out_beat
);
  import vpm_pkg::*;

  // input, product, divider stages, output register
  localparam int NST = DIV_STAGES + 3;
  localparam int G_W = DVD_W + 2;
  localparam logic signed [G_W-1:0] G_MAX = G_W'(32767);
  localparam logic signed [G_W-1:0] G_MIN = -G_W'(32768);

  typedef struct packed {
    logic signed [DF_W-1:0] diff;
    logic                   neg;
    logic                   inr;
    logic [DVD_W-1:0]       dvd;
    logic [DW_W-1:0]        rem;
  } ax_t;

  typedef struct packed {
    ax_t x;
    ax_t y;
  } stg_t;

  typedef struct packed {
    logic [PT_W-1:0] g;
    logic [CL_W-1:0] cl;
  } axo_t;

  logic [NST-1:0] v_r;
  logic [NST:0]   en;
  stg_t           st_r [NST-1];
  res_t           res_r;
  stg_t           s0;
  axo_t           ox, oy;

  function automatic ax_t ax_prod(input ax_t a, input ax_lay_t l);
    ax_t             r;
    logic [DF_W-1:0] mag;
    r     = a;
    r.neg = (a.diff < 0);
    mag   = r.neg ? DF_W'(-a.diff) : DF_W'(a.diff);
    r.dvd = mag * l.surf;
    r.rem = '0;
    r.inr = (a.diff >= 0) && (a.diff < $signed({1'b0, l.size}));
    return r;
  endfunction

  function automatic ax_t ax_div(input ax_t a, input logic [DW_W-1:0] d);
    ax_t           r;
    logic [DW_W:0] t;
    r = a;
    for (int i = 0; i < BPS; i++) begin
      t     = {r.rem, r.dvd[DVD_W-1]};
      r.dvd = {r.dvd[DVD_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t        = t - {1'b0, d};
        r.dvd[0] = 1'b1;
      end
      r.rem = t[DW_W-1:0];
    end
    return r;
  endfunction

  function automatic axo_t ax_out(input ax_t a, input ax_lay_t l, input logic scaled);
    axo_t                   o;
    logic signed [G_W-1:0]  g, q, smax;
    q    = $signed({2'b00, a.dvd});
    smax = $signed(G_W'(l.surf)) - G_W'(1);
    if (scaled) g = a.neg ? -q : q;
    else g = $signed(G_W'(l.src)) + G_W'(a.diff);
    if (g > G_MAX) o.g = PT_W'(G_MAX);
    else if (g < G_MIN) o.g = PT_W'(G_MIN);
    else o.g = g[PT_W-1:0];
    if (g < 0) o.cl = '0;
    else if (g > smax) o.cl = smax[CL_W-1:0];
    else o.cl = g[CL_W-1:0];
    return o;
  endfunction

  // Stage loads: a stage moves when it is empty or the next one moves
  always_comb begin
    en[NST] = out_ready;
    for (int k = NST - 1; k >= 0; k--) en[k] = !v_r[k] || en[k+1];
  end

  assign in_ready = en[0] && lay_rdy;

  // Offset subtraction
  always_comb begin
    s0        = '0;
    s0.x.diff = DF_W'(in_beat.pointer_x) - DF_W'(lay.x.off);
    s0.y.diff = DF_W'(in_beat.pointer_y) - DF_W'(lay.y.off);
  end

  // Final result per axis
  assign ox = ax_out(st_r[NST-2].x, lay.x, lay.scaled);
  assign oy = ax_out(st_r[NST-2].y, lay.y, lay.scaled);

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid && in_ready;
      for (int k = 1; k < NST; k++)
        if (en[k]) v_r[k] <= v_r[k-1];
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    if (en[0]) st_r[0] <= s0;
    if (en[1]) begin
      st_r[1].x <= ax_prod(st_r[0].x, lay.x);
      st_r[1].y <= ax_prod(st_r[0].y, lay.y);
    end
    for (int k = 2; k < NST - 1; k++) begin
      if (en[k]) begin
        st_r[k].x <= ax_div(st_r[k-1].x, lay.x.size);
        st_r[k].y <= ax_div(st_r[k-1].y, lay.y.size);
      end
    end
    if (en[NST-1]) begin
      if (lay.valid) begin
        res_r.guest_x      <= ox.g;
        res_r.guest_y      <= oy.g;
        res_r.inside_res   <= st_r[NST-2].x.inr && st_r[NST-2].y.inr;
        res_r.layout_valid <= 1'b1;
        res_r.clamped_x    <= ox.cl;
        res_r.clamped_y    <= oy.cl;
      end else begin
        res_r <= '0;
      end
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_beat  = res_r;

endmodule

// ----- hdl/viewport_pointer_mapper_unit.sv -----
// Viewport pointer mapper: turns a pointer position on the display canvas into a
// source-surface pixel under one of four view modes (stretch, aspect fit, integer
// scale, one to one), chosen through the cfg_ write port. One pointer beat is taken
// every cycle unless out_res.ready back-pressure or a layout computation holds it off;
// each result passes through the mapping pipeline (offset, multiply, a 16-stage
// two-bits-per-stage divider, output register). Every configuration write starts a
// layout computation (setup, a 28-step radix-2 divider for the aspect fit, result),
// during which in_pt.ready stays low; the same applies after reset.
module viewport_pointer_mapper_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  vpm_in_if.sink                           in_pt,
  vpm_out_if.source                        out_res,
  input  logic                             cfg_we,
  input  logic [vpm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [vpm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import vpm_pkg::*;

  cfg_t cfg_r;
  lay_t lay;
  logic lay_rdy;
  pt_t  in_beat;
  res_t out_beat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{view_mode: VM_ONE, scale_factor: SCALE_W'(1), default: '0};
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SURFACE_W: cfg_r.surface_width  <= CFG_SW_W'(cfg_wdata);
        REG_SURFACE_H: cfg_r.surface_height <= CFG_SW_W'(cfg_wdata);
        REG_CANVAS_W:  cfg_r.canvas_width   <= CFG_CW_W'(cfg_wdata);
        REG_CANVAS_H:  cfg_r.canvas_height  <= CFG_CW_W'(cfg_wdata);
        REG_VIEW_MODE: cfg_r.view_mode      <= MODE_W'(cfg_wdata);
        REG_SCALE:     cfg_r.scale_factor   <= SCALE_W'(cfg_wdata);
        REG_SCROLL_X:  cfg_r.scroll_x       <= SCROLL_W'(cfg_wdata);
        REG_SCROLL_Y:  cfg_r.scroll_y       <= SCROLL_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  vpm_layout u_layout (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .cfg_we  (cfg_we),
    .lay     (lay),
    .lay_rdy (lay_rdy)
  );

  assign in_beat.pointer_x = in_pt.pointer_x;
  assign in_beat.pointer_y = in_pt.pointer_y;

  vpm_map u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pt.valid),
    .in_ready  (in_pt.ready),
    .in_beat   (in_beat),
    .lay_rdy   (lay_rdy),
    .lay       (lay),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .out_beat  (out_beat)
  );

  assign out_res.guest_x      = out_beat.guest_x;
  assign out_res.guest_y      = out_beat.guest_y;
  assign out_res.inside_res   = out_beat.inside_res;
  assign out_res.layout_valid = out_beat.layout_valid;
  assign out_res.clamped_x    = out_beat.clamped_x;
  assign out_res.clamped_y    = out_beat.clamped_y;

endmodule

// ----- hdl/vpm_chk.sv -----
module vpm_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           cfg_we,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [vpm_pkg::PT_W-1:0] guest_x,
  input logic signed [vpm_pkg::PT_W-1:0] guest_y,
  input logic                           inside_res,
  input logic                           layout_valid,
  input logic [vpm_pkg::CL_W-1:0]       clamped_x,
  input logic [vpm_pkg::CL_W-1:0]       clamped_y
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // and keeps its guest_x, guest_y and clamped_x payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(guest_x) && $stable(guest_y) && $stable(clamped_x))
    else $error("result payload changed while stalled");

  // a register write holds off input while the layout is rebuilt
  a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("input taken during layout rebuild");

  // pointer can only be inside a real layout
  a_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && inside_res |-> layout_valid)
    else $error("inside flagged with empty layout");

  // empty layout gives all-zero fields
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !layout_valid |->
      guest_x == 0 && guest_y == 0 && clamped_x == 0 && clamped_y == 0)
    else $error("non-zero result with empty layout");

endmodule

bind viewport_pointer_mapper_unit vpm_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .cfg_we       (cfg_we),
  .in_ready     (in_pt.ready),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .guest_x      (out_res.guest_x),
  .guest_y      (out_res.guest_y),
  .inside_res   (out_res.inside_res),
  .layout_valid (out_res.layout_valid),
  .clamped_x    (out_res.clamped_x),
  .clamped_y    (out_res.clamped_y)
);
